FILE: hw/rtl/skcs_pkg.sv
// Package for the skyline contour sweep.
// Holds the FSM state type, result status codes and the cell control struct.
// No dependencies.
`default_nettype none

package skcs_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    typedef enum logic [1:0] {
        ST_POINT     = 2'd0,
        ST_UNMATCHED = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_END   = 1'b1;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/skcs_cell.sv
// One cell of the sorted open-height chain (descending, valid entries packed at the front).
// Compares its entry with the request height, then shifts right on insert or left on remove.
// Depends on skcs_pkg.
`default_nettype none

module skcs_cell
    import skcs_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [COORD_BITS-1:0] i_h,
    input  wire logic [COORD_BITS-1:0] i_left_val,
    input  wire logic                  i_left_valid,
    input  wire logic                  i_left_ge,
    input  wire logic [COORD_BITS-1:0] i_right_val,
    input  wire logic                  i_right_valid,
    output logic [COORD_BITS-1:0]      o_val,
    output logic                       o_valid,
    output logic                       o_ge,
    output logic                       o_gt,
    output logic                       o_eq
);

    logic [COORD_BITS-1:0] r_val;
    logic                  r_valid;
    logic                  r_ge;
    logic                  r_gt;
    logic [COORD_BITS-1:0] n_val;
    logic                  n_valid;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctl.ins && !r_ge) begin
            if (i_left_ge) begin
                n_val   = i_h;
                n_valid = 1'b1;
            end else begin
                n_val   = i_left_val;
                n_valid = i_left_valid;
            end
        end else if (i_ctl.rem && !r_gt) begin
            n_val   = i_right_val;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_ctl.cmp) begin
            r_ge <= r_valid && (r_val >= i_h);
            r_gt <= r_valid && (r_val > i_h);
        end
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;
    assign o_ge    = r_ge;
    assign o_gt    = r_gt;
    assign o_eq    = r_valid && (r_val == i_h);

endmodule

`default_nettype wire

FILE: hw/rtl/skyline_contour_sweep.sv
// Skyline contour sweep: each accepted request passes the compare state, then the shift state
// in the cell chain (S_CMP, then S_APPLY); its result is registered on leaving the shift state.
// The next request is taken in the shift cycle while the result register is free or drains.
// Synchronous active-low reset empties the open-height chain and idles the sequencer.
// Depends on skcs_pkg and skcs_cell.
`default_nettype none

module skyline_contour_sweep
    import skcs_pkg::*;
#(
    parameter int MAX_OPEN   = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_cmd,
    input  wire logic [COORD_BITS-1:0] i_event_x,
    input  wire logic [COORD_BITS-1:0] i_event_h,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [COORD_BITS-1:0]      o_point_x,
    output logic [COORD_BITS-1:0]      o_point_y,
    output logic [1:0]                 o_status
);

    t_state                r_state;
    t_state                n_state;
    logic                  r_cmd;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_h;
    logic                  r_match;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_point_x;
    logic [COORD_BITS-1:0] r_point_y;
    t_status               r_status;

    logic [COORD_BITS-1:0] w_val   [MAX_OPEN];
    logic [MAX_OPEN-1:0]   w_valid;
    logic [MAX_OPEN-1:0]   w_ge;
    logic [MAX_OPEN-1:0]   w_gt;
    logic [MAX_OPEN-1:0]   w_eq;

    t_cell_ctl             w_ctl;
    logic                  w_finish;
    logic                  w_full;
    logic [COORD_BITS-1:0] w_old_max;
    logic [COORD_BITS-1:0] w_new_max;
    logic                  w_emit;
    t_status               w_status;

    assign w_finish  = !r_out_valid || i_out_ready;
    assign w_full    = w_valid[MAX_OPEN-1];
    assign w_old_max = w_valid[0] ? w_val[0] : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_finish) n_state = i_in_valid ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_ctl      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_CMP: begin
                w_ctl.cmp = 1'b1;
            end
            S_APPLY: begin
                o_in_ready = w_finish;
                w_ctl.ins  = w_finish && (r_cmd == CMD_START) && !w_full;
                w_ctl.rem  = w_finish && (r_cmd == CMD_END) && r_match;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_new_max = w_old_max;
        w_emit    = 1'b0;
        w_status  = ST_POINT;
        if (r_cmd == CMD_START) begin
            if (w_full) begin
                w_emit   = 1'b1;
                w_status = ST_FULL;
            end else begin
                w_new_max = w_ge[0] ? w_old_max : r_h;
                w_emit    = (w_new_max != w_old_max);
            end
        end else begin
            if (!r_match) begin
                w_emit   = 1'b1;
                w_status = ST_UNMATCHED;
            end else begin
                if (!w_gt[0]) w_new_max = w_valid[1] ? w_val[1] : '0;
                w_emit = (w_new_max != w_old_max);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_APPLY && w_finish) begin
                r_out_valid <= w_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= i_cmd;
            r_x   <= i_event_x;
            r_h   <= i_event_h;
        end
        if (r_state == S_CMP) r_match <= |w_eq;
        if (r_state == S_APPLY && w_finish && w_emit) begin
            r_point_x <= r_x;
            r_point_y <= w_new_max;
            r_status  <= w_status;
        end
    end

    for (genvar gi = 0; gi < MAX_OPEN; gi++) begin : g_cell
        logic [COORD_BITS-1:0] w_left_val;
        logic                  w_left_valid;
        logic                  w_left_ge;
        logic [COORD_BITS-1:0] w_right_val;
        logic                  w_right_valid;

        if (gi == 0) begin : g_head
            assign w_left_val   = '0;
            assign w_left_valid = 1'b0;
            assign w_left_ge    = 1'b1;
        end else begin : g_mid
            assign w_left_val   = w_val[gi-1];
            assign w_left_valid = w_valid[gi-1];
            assign w_left_ge    = w_ge[gi-1];
        end

        if (gi == MAX_OPEN - 1) begin : g_tail
            assign w_right_val   = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_body
            assign w_right_val   = w_val[gi+1];
            assign w_right_valid = w_valid[gi+1];
        end

        skcs_cell #(
            .COORD_BITS(COORD_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_h          (r_h),
            .i_left_val   (w_left_val),
            .i_left_valid (w_left_valid),
            .i_left_ge    (w_left_ge),
            .i_right_val  (w_right_val),
            .i_right_valid(w_right_valid),
            .o_val        (w_val[gi]),
            .o_valid      (w_valid[gi]),
            .o_ge         (w_ge[gi]),
            .o_gt         (w_gt[gi]),
            .o_eq         (w_eq[gi])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_point_x;
    assign o_point_y   = r_point_y;
    assign o_status    = r_status;

endmodule

`default_nettype wire

FILE: test/tb.sv
// Testbench for skyline_contour_sweep: sorted building sweeps, stray events and store overflow.
// A clocked driver feeds requests from a queue; a contour predictor checks every result.
// Depends on skcs_pkg and the skyline_contour_sweep RTL.
`timescale 1ns / 100ps

module tb;
    import skcs_pkg::*;

    localparam int MAX_OPEN   = 64;
    localparam int COORD_BITS = 16;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] h;
    } t_sweep_ev;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        t_status               st;
    } t_contour_pt;

    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_cmd = CMD_START;
    logic [COORD_BITS-1:0] in_x = '0;
    logic [COORD_BITS-1:0] in_h = '0;
    logic                  out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [COORD_BITS-1:0] o_point_x;
    logic [COORD_BITS-1:0] o_point_y;
    logic [1:0]            o_status;

    t_sweep_ev   sweep_events[$];
    t_contour_pt pending_points[$];
    logic [COORD_BITS-1:0] stray_heights[$];

    logic [COORD_BITS-1:0] open_h[MAX_OPEN];
    bit                    open_v[MAX_OPEN];
    logic [COORD_BITS-1:0] skyline_h = '0;

    t_phase phase = PH_FREE;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_left = 0;
    bit     hold_armed = 1'b1;
    int     n_queued = 0;
    int     seq_idx = 0;
    int     n_fail = 0;

    skyline_contour_sweep #(
        .MAX_OPEN   (MAX_OPEN),
        .COORD_BITS (COORD_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (in_cmd),
        .i_event_x   (in_x),
        .i_event_h   (in_h),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_status    (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void note_point(input logic [COORD_BITS-1:0] x,
                                       input logic [COORD_BITS-1:0] y, input t_status st);
        t_contour_pt pt;
        pt = '{x, y, st};
        pending_points.insert(pending_points.size(), pt);
    endfunction

    // Track the open-height store and the contour; queue the result an event causes.
    function automatic void skyline_apply(input logic kind, input logic [COORD_BITS-1:0] x,
                                          input logic [COORD_BITS-1:0] h);
        int slot;
        logic [COORD_BITS-1:0] top;
        slot = -1;
        top = '0;
        if (kind == CMD_START) begin
            for (int i = 0; i < MAX_OPEN; i++)
                if (!open_v[i] && slot < 0) slot = i;
            if (slot < 0) begin
                note_point(x, skyline_h, ST_FULL);
            end else begin
                open_h[slot] = h;
                open_v[slot] = 1'b1;
                if (h > skyline_h) begin
                    skyline_h = h;
                    note_point(x, h, ST_POINT);
                end
            end
        end else begin
            for (int i = 0; i < MAX_OPEN; i++)
                if (open_v[i] && open_h[i] == h && slot < 0) slot = i;
            if (slot < 0) begin
                note_point(x, skyline_h, ST_UNMATCHED);
            end else begin
                open_v[slot] = 1'b0;
                if (h == skyline_h) begin
                    for (int i = 0; i < MAX_OPEN; i++)
                        if (open_v[i] && open_h[i] > top) top = open_h[i];
                    if (top != skyline_h) begin
                        skyline_h = top;
                        note_point(x, top, ST_POINT);
                    end
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin : driver_blk
        t_sweep_ev nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) skyline_apply(in_cmd, in_x, in_h);
            if (!in_valid || o_in_ready) begin
                if (sweep_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = sweep_events.pop_front();
                    in_cmd   <= nxt.kind;
                    in_x     <= nxt.x;
                    in_h     <= nxt.h;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Hold the receiver off once, long enough for the block to back up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (phase == PH_PRESSURE && hold_armed) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : monitor_blk
        t_contour_pt want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pending_points.size() == 0) begin
                    $error("unexpected point x=%0d y=%0d status=%0d",
                           o_point_x, o_point_y, o_status);
                    n_fail++;
                end else begin
                    want = pending_points.pop_front();
                    if (o_point_x !== want.x) begin
                        $error("point_x expected %0d actual %0d", want.x, o_point_x);
                        n_fail++;
                    end
                    if (o_point_y !== want.y) begin
                        $error("point_y expected %0d actual %0d", want.y, o_point_y);
                        n_fail++;
                    end
                    if (o_status !== want.st) begin
                        $error("status expected %0d actual %0d", want.st, o_status);
                        n_fail++;
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_ev(input logic kind, input int x, input int h);
        t_sweep_ev ev;
        ev = '{kind, x[COORD_BITS-1:0], h[COORD_BITS-1:0]};
        sweep_events.insert(sweep_events.size(), ev);
        n_queued++;
    endtask

    function automatic int pick_height();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 0;
            1: return 16'hFFFF;
            2, 3, 4, 5: return $urandom_range(1, 12) * 100;
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    // One sweep over random buildings; a wide sweep keeps more open than the store holds.
    task automatic push_skyline(input bit wide);
        t_sweep_ev evs[$];
        t_sweep_ev tmp;
        int n_bld, base, lft, rgt, hh, j;
        n_bld = wide ? $urandom_range(66, 72) : $urandom_range(1, 24);
        base = $urandom_range(0, 65535 - 1200);
        for (int b = 0; b < n_bld; b++) begin
            if (wide) begin
                lft = base + $urandom_range(0, 100);
                rgt = base + $urandom_range(200, 300);
            end else begin
                lft = base + $urandom_range(0, 600);
                rgt = lft + $urandom_range(0, 400);
            end
            hh = pick_height();
            tmp = '{CMD_START, lft[COORD_BITS-1:0], hh[COORD_BITS-1:0]};
            evs.insert(evs.size(), tmp);
            tmp = '{CMD_END, rgt[COORD_BITS-1:0], hh[COORD_BITS-1:0]};
            evs.insert(evs.size(), tmp);
        end
        for (int i = 1; i < evs.size(); i++) begin
            tmp = evs[i];
            j = i - 1;
            while (j >= 0 && {evs[j].x, evs[j].kind} > {tmp.x, tmp.kind}) begin
                evs[j+1] = evs[j];
                j--;
            end
            evs[j+1] = tmp;
        end
        foreach (evs[i]) queue_ev(evs[i].kind, evs[i].x, evs[i].h);
    endtask

    task automatic flush_strays();
        while (stray_heights.size() > 0)
            queue_ev(CMD_END, $urandom_range(0, 16'hFFFF), stray_heights.pop_front());
    endtask

    task automatic run_phase(input t_phase ph, input int s_pct, input int r_pct, input int n);
        int stop_at, kind, hh;
        @(negedge i_clk);
        phase = ph;
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        stop_at = n_queued + n;
        while (n_queued < stop_at) begin
            push_skyline(seq_idx % 8 == 2);
            seq_idx++;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    kind = $urandom_range(0, 1);
                    hh = $urandom_range(0, 1) ? pick_height() : $urandom_range(0, 16'hFFFF);
                    queue_ev(kind[0], $urandom_range(0, 16'hFFFF), hh);
                    if (kind[0] == CMD_START)
                        stray_heights.insert(stray_heights.size(), hh[COORD_BITS-1:0]);
                end
            end
            if ($urandom_range(0, 2) == 0) flush_strays();
        end
        flush_strays();
        while (sweep_events.size() > 0 || in_valid || pending_points.size() > 0)
            @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        queue_ev(CMD_END,   0,      5);
        queue_ev(CMD_START, 0,      0);
        queue_ev(CMD_END,   0,      0);
        queue_ev(CMD_START, 1,      16'hFFFF);
        queue_ev(CMD_START, 1,      100);
        queue_ev(CMD_START, 2,      100);
        queue_ev(CMD_START, 3,      16'hFFFF);
        queue_ev(CMD_END,   4,      100);
        queue_ev(CMD_END,   5,      16'hFFFF);
        queue_ev(CMD_END,   6,      16'hFFFF);
        queue_ev(CMD_END,   7,      7);
        queue_ev(CMD_END,   8,      100);
        queue_ev(CMD_START, 16'hFFFF, 16'hAAAA);
        queue_ev(CMD_START, 16'hFFFF, 16'h5555);
        queue_ev(CMD_END,   16'hFFFF, 16'h5555);
        queue_ev(CMD_END,   16'hFFFF, 16'hAAAA);
        while (sweep_events.size() > 0 || in_valid || pending_points.size() > 0)
            @(negedge i_clk);
        run_phase(PH_FREE,       0,  0,  250);
        run_phase(PH_SEND_IDLE,  71, 0,  200);
        run_phase(PH_RECV_STALL, 0,  71, 250);
        run_phase(PH_BOTH,       34, 34, 250);
        run_phase(PH_PRESSURE,   0,  0,  150);
        repeat (20) @(negedge i_clk);
        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
